[src/oaie_pkg.sv]
// Package for the ordered array block: sizes, field widths, codes and shared types.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package oaie_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    localparam int OP_W       = 3;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int FPOS_W     = 4;
    localparam int RWORD_W    = 32;
    localparam int ENTRY_CT_W = 5;

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [COUNT_W-1:0]           cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND,
        OP_INSERT,
        OP_ERASE,
        OP_FIND,
        OP_READ
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_FULL,
        STATUS_RANGE,
        STATUS_MISSING
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        idx_t     pos;
        cnt_t     count;
        word_t    key;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_ERASE
    } state_t;

    function automatic word_t widen_value(input logic signed [VALUE_W-1:0] v);
        return WORD_WIDTH'(v);
    endfunction

    function automatic logic [RWORD_W-1:0] to_read_word(input word_t w);
        logic [WORD_WIDTH-1:0] u;
        u = w;
        return RWORD_W'(u);
    endfunction

endpackage

`default_nettype wire

[src/oaie_req_if.sv]
// Request channel: valid/ready handshake with operation, value and position.
// Depends on oaie_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface oaie_req_if;

    logic                                    valid;
    logic                                    ready;
    logic [oaie_pkg::OP_W-1:0]               operation;
    logic signed [oaie_pkg::VALUE_W-1:0]     value;
    logic [oaie_pkg::POS_W-1:0]              position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
    modport monitor (input valid, input ready, input operation, input value,
                     input position);

endinterface

`default_nettype wire

[src/oaie_rsp_if.sv]
// Result channel: valid/ready handshake with status, position, read word and count.
// Depends on oaie_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface oaie_rsp_if;

    logic                                    valid;
    logic                                    ready;
    logic [oaie_pkg::STATUS_W-1:0]           status;
    logic [oaie_pkg::FPOS_W-1:0]             found_position;
    logic signed [oaie_pkg::RWORD_W-1:0]     read_word;
    logic [oaie_pkg::ENTRY_CT_W-1:0]         entry_count;

    modport source (output valid, output status, output found_position,
                    output read_word, output entry_count, input ready);
    modport sink   (input valid, input status, input found_position,
                    input read_word, input entry_count, output ready);
    modport monitor (input valid, input ready, input status, input found_position,
                     input read_word, input entry_count);

endinterface

`default_nettype wire

[src/oaie_cell.sv]
// One list slot: holds an entry, compares it to the key, and takes a neighbor's
// entry on insert (shift up) or erase (shift down). Depends on oaie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oaie_cell (
    input  wire logic               clk,
    input  wire oaie_pkg::idx_t     idx,
    input  wire oaie_pkg::cell_cmd_t cmd,
    input  wire oaie_pkg::word_t    left_word,
    input  wire oaie_pkg::word_t    right_word,
    input  wire logic               above_in,
    output oaie_pkg::word_t         word,
    output logic                    match,
    output logic                    above_out
);

    oaie_pkg::word_t entry_reg;
    oaie_pkg::word_t entry_next;
    logic            valid;

    assign valid     = oaie_pkg::COUNT_W'(idx) < cmd.count;
    assign match     = valid && (entry_reg == cmd.key);
    assign above_out = above_in | match;
    assign word      = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            oaie_pkg::CELL_INSERT:
            begin
                if (idx == cmd.pos)
                begin
                    entry_next = cmd.key;
                end
                else if ((idx > cmd.pos) && (oaie_pkg::COUNT_W'(idx) <= cmd.count))
                begin
                    entry_next = left_word;
                end
            end
            oaie_pkg::CELL_ERASE:
            begin
                // at or above the lowest match: close the gap
                if (above_in || match)
                begin
                    entry_next = right_word;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

[src/ordered_array_insert_erase.sv]
// Top level of the ordered array: request decode, erase sequencer, result register.
// Depends on oaie_pkg, oaie_req_if, oaie_rsp_if and oaie_cell.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed words kept in a row of cells, one entry
// per cell. Append, insert, find and read finish in the cycle the request is
// accepted; the result is registered and a new request is taken the next cycle,
// also while the previous result still waits, as long as the result register is
// freed that cycle. Erase removes the lowest matching entry per cycle as the
// cells shift down, until no entry matches; then the result is registered and
// the sequencer returns to idle. No request is taken while an erase is under way.
// Entries above the count are never read, so they need no reset.
module ordered_array_insert_erase (
    input  wire logic   clk,
    input  wire logic   rst_n,
    oaie_req_if.sink    req,
    oaie_rsp_if.source  rsp
);

    localparam int N = oaie_pkg::CAPACITY;

    oaie_pkg::state_t   state_reg, state_next;
    oaie_pkg::cnt_t     count_reg, count_next;
    oaie_pkg::word_t    key_reg, key_next;
    logic               erased_reg, erased_next;

    logic                                 rsp_valid_reg, rsp_valid_next;
    oaie_pkg::status_t                    status_reg, status_next;
    logic [oaie_pkg::FPOS_W-1:0]          fpos_reg, fpos_next;
    logic [oaie_pkg::RWORD_W-1:0]         rword_reg, rword_next;
    logic [oaie_pkg::ENTRY_CT_W-1:0]      ecount_reg, ecount_next;

    oaie_pkg::cell_cmd_t cmd;
    oaie_pkg::word_t     word_q [N];
    logic [N-1:0]        match;
    logic [N:0]          above;
    logic [N-1:0]        first;
    oaie_pkg::idx_t      first_idx;
    logic                any_match;
    logic                accept;
    logic                full;
    oaie_pkg::op_t       op;

    assign above[0]  = 1'b0;
    assign any_match = above[N];
    assign op        = oaie_pkg::op_t'(req.operation);
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == oaie_pkg::COUNT_W'(N);

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            oaie_pkg::word_t left_w;
            oaie_pkg::word_t right_w;
            if (g == 0)
            begin : g_first
                assign left_w = word_q[g];
            end
            else
            begin : g_mid_l
                assign left_w = word_q[g-1];
            end
            if (g == N - 1)
            begin : g_last
                assign right_w = word_q[g];
            end
            else
            begin : g_mid_r
                assign right_w = word_q[g+1];
            end

            oaie_cell u_cell (
                .clk        (clk),
                .idx        (oaie_pkg::IDX_W'(g)),
                .cmd        (cmd),
                .left_word  (left_w),
                .right_word (right_w),
                .above_in   (above[g]),
                .word       (word_q[g]),
                .match      (match[g]),
                .above_out  (above[g+1])
            );

            assign first[g] = match[g] & ~above[g];
        end
    endgenerate

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (first[i])
            begin
                first_idx = first_idx | oaie_pkg::IDX_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oaie_pkg::ST_IDLE:
            begin
                if (accept && (op == oaie_pkg::OP_ERASE))
                begin
                    state_next = oaie_pkg::ST_ERASE;
                end
            end
            oaie_pkg::ST_ERASE:
            begin
                if (!any_match)
                begin
                    state_next = oaie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oaie_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        logic                      load;
        oaie_pkg::status_t         st;
        logic [oaie_pkg::FPOS_W-1:0]  fp;
        logic [oaie_pkg::RWORD_W-1:0] rw;

        load        = 1'b0;
        st          = oaie_pkg::STATUS_OK;
        fp          = '0;
        rw          = '0;
        req.ready   = 1'b0;
        count_next  = count_reg;
        key_next    = key_reg;
        erased_next = erased_reg;

        cmd.op    = oaie_pkg::CELL_HOLD;
        cmd.pos   = count_reg[oaie_pkg::IDX_W-1:0];
        cmd.count = count_reg;
        cmd.key   = (state_reg == oaie_pkg::ST_ERASE) ? key_reg
                                                      : oaie_pkg::widen_value(req.value);

        case (state_reg)
            oaie_pkg::ST_IDLE:
            begin
                req.ready = !rsp_valid_reg || rsp.ready;
                if (accept)
                begin
                    case (op)
                        oaie_pkg::OP_APPEND:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                st = oaie_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cmd.op     = oaie_pkg::CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        oaie_pkg::OP_INSERT:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                st = oaie_pkg::STATUS_FULL;
                            end
                            else if (32'(req.position) > 32'(count_reg))
                            begin
                                st = oaie_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                cmd.op     = oaie_pkg::CELL_INSERT;
                                cmd.pos    = oaie_pkg::IDX_W'(req.position);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        oaie_pkg::OP_ERASE:
                        begin
                            key_next    = oaie_pkg::widen_value(req.value);
                            erased_next = 1'b0;
                        end
                        oaie_pkg::OP_FIND:
                        begin
                            load = 1'b1;
                            if (any_match)
                            begin
                                fp = oaie_pkg::FPOS_W'(first_idx);
                            end
                            else
                            begin
                                st = oaie_pkg::STATUS_MISSING;
                            end
                        end
                        oaie_pkg::OP_READ:
                        begin
                            load = 1'b1;
                            if (32'(req.position) >= 32'(count_reg))
                            begin
                                st = oaie_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                rw = oaie_pkg::to_read_word(
                                         word_q[oaie_pkg::IDX_W'(req.position)]);
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            oaie_pkg::ST_ERASE:
            begin
                if (any_match)
                begin
                    cmd.op      = oaie_pkg::CELL_ERASE;
                    count_next  = count_reg - 1'b1;
                    erased_next = 1'b1;
                end
                else
                begin
                    load = 1'b1;
                    st   = erased_reg ? oaie_pkg::STATUS_OK : oaie_pkg::STATUS_MISSING;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        rsp_valid_next = load ? 1'b1 : (rsp_valid_reg && !rsp.ready);
        status_next    = load ? st : status_reg;
        fpos_next      = load ? fp : fpos_reg;
        rword_next     = load ? rw : rword_reg;
        ecount_next    = load ? oaie_pkg::ENTRY_CT_W'(count_next) : ecount_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oaie_pkg::ST_IDLE;
            count_reg     <= '0;
            erased_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            erased_reg    <= erased_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        status_reg <= status_next;
        fpos_reg   <= fpos_next;
        rword_reg  <= rword_next;
        ecount_reg <= ecount_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.found_position = fpos_reg;
    assign rsp.read_word      = signed'(rword_reg);
    assign rsp.entry_count    = ecount_reg;

endmodule

`default_nettype wire

[src/oaie_checker.sv]
// Port-level checks for the ordered array block, attached to the top by bind.
// Depends on oaie_pkg and on the handshake and result ports of the top level.
`timescale 1ns / 1ps
`default_nettype none

module oaie_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_ready,
    input  wire logic                              rsp_valid,
    input  wire logic                              rsp_ready,
    input  wire logic [oaie_pkg::STATUS_W-1:0]     rsp_status,
    input  wire logic [oaie_pkg::FPOS_W-1:0]       rsp_found_position,
    input  wire logic [oaie_pkg::RWORD_W-1:0]      rsp_read_word,
    input  wire logic [oaie_pkg::ENTRY_CT_W-1:0]   rsp_entry_count
);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_entry_count) <= oaie_pkg::CAPACITY))
        else $error("entry_count above capacity");

    a_fpos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != oaie_pkg::STATUS_OK)) |-> (rsp_found_position == '0))
        else $error("found_position set on failed request");

    a_rword_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != oaie_pkg::STATUS_OK)) |-> (rsp_read_word == '0))
        else $error("read_word set on failed request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                       && $stable(rsp_entry_count)))
        else $error("stalled result changed");

    a_no_req_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !req_ready)
        else $error("request taken while result slot is blocked");

endmodule

bind ordered_array_insert_erase oaie_checker u_oaie_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_found_position (rsp.found_position),
    .rsp_read_word      (rsp.read_word),
    .rsp_entry_count    (rsp.entry_count)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for ordered_array_insert_erase: directed table, then random requests.
// Depends on oaie_pkg, oaie_req_if, oaie_rsp_if and the block itself.
`timescale 1ns / 1ps

module testbench;

    localparam logic [oaie_pkg::OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [oaie_pkg::OP_W-1:0] OP_SPARE_HI  = 3'd7;
    localparam int                        N_DIRECTED   = 16;
    localparam int                        RANDOM_ITEMS = 1420;
    localparam int                        POOL_SIZE    = 6;
    localparam int                        DRAIN_CYCLES = 24;

    typedef struct packed {
        oaie_pkg::status_t                 status;
        logic [oaie_pkg::FPOS_W-1:0]       fpos;
        logic [oaie_pkg::RWORD_W-1:0]      rword;
        logic [oaie_pkg::ENTRY_CT_W-1:0]   count;
    } outcome_t;

    typedef struct {
        logic [oaie_pkg::OP_W-1:0]           op;
        logic signed [oaie_pkg::VALUE_W-1:0] value;
        logic [oaie_pkg::POS_W-1:0]          pos;
        int                                  reps;
        bit                                  has_want;
        outcome_t                            want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    oaie_req_if req_ch ();
    oaie_rsp_if rsp_ch ();

    ordered_array_insert_erase uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    oaie_pkg::word_t                     list_words [oaie_pkg::CAPACITY];
    int                                  list_len;
    outcome_t                            outcome_q [$];
    logic signed [oaie_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
    int                                  burst_left;
    int                                  mismatches;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{oaie_pkg::OP_READ,   32'sd0,         5'd0,  1,  1'b1,
          '{oaie_pkg::STATUS_RANGE,   4'd0, 32'd0, 5'd0}},
        '{oaie_pkg::OP_FIND,   32'sd0,         5'd0,  1,  1'b1,
          '{oaie_pkg::STATUS_MISSING, 4'd0, 32'd0, 5'd0}},
        '{oaie_pkg::OP_ERASE,  32'sd0,         5'd0,  1,  1'b1,
          '{oaie_pkg::STATUS_MISSING, 4'd0, 32'd0, 5'd0}},
        '{oaie_pkg::OP_INSERT, 32'sd9,         5'd1,  1,  1'b1,
          '{oaie_pkg::STATUS_RANGE,   4'd0, 32'd0, 5'd0}},
        '{oaie_pkg::OP_APPEND, 32'sh7FFF_FFFF, 5'd0,  1,  1'b1,
          '{oaie_pkg::STATUS_OK,      4'd0, 32'd0, 5'd1}},
        '{oaie_pkg::OP_APPEND, 32'sh8000_0000, 5'd0,  1,  1'b1,
          '{oaie_pkg::STATUS_OK,      4'd0, 32'd0, 5'd2}},
        '{oaie_pkg::OP_INSERT, -32'sd1,        5'd0,  1,  1'b1,
          '{oaie_pkg::STATUS_OK,      4'd0, 32'd0, 5'd3}},
        '{oaie_pkg::OP_INSERT, 32'sd0,         5'd3,  1,  1'b1,
          '{oaie_pkg::STATUS_OK,      4'd0, 32'd0, 5'd4}},
        '{oaie_pkg::OP_READ,   32'sd0,         5'd1,  1,  1'b1,
          '{oaie_pkg::STATUS_OK,      4'd0, 32'h7FFF_FFFF, 5'd4}},
        '{oaie_pkg::OP_READ,   32'sd0,         5'd31, 1,  1'b1,
          '{oaie_pkg::STATUS_RANGE,   4'd0, 32'd0, 5'd4}},
        '{oaie_pkg::OP_FIND,   32'sd0,         5'd0,  1,  1'b1,
          '{oaie_pkg::STATUS_OK,      4'd3, 32'd0, 5'd4}},
        '{OP_SPARE_HI,         -32'sd1,        5'd31, 1,  1'b1,
          '{oaie_pkg::STATUS_OK,      4'd0, 32'd0, 5'd4}},
        '{oaie_pkg::OP_APPEND, 32'sd5,         5'd0,  12, 1'b0, '0},
        '{oaie_pkg::OP_APPEND, 32'sd1,         5'd0,  1,  1'b1,
          '{oaie_pkg::STATUS_FULL,    4'd0, 32'd0, 5'd16}},
        '{oaie_pkg::OP_INSERT, 32'sd1,         5'd31, 1,  1'b1,
          '{oaie_pkg::STATUS_FULL,    4'd0, 32'd0, 5'd16}},
        '{oaie_pkg::OP_ERASE,  32'sd5,         5'd0,  1,  1'b0, '0}
    };

    // list model: one call per accepted request
    function automatic outcome_t apply_request(input logic [oaie_pkg::OP_W-1:0] op,
                                               input logic signed [oaie_pkg::VALUE_W-1:0] val,
                                               input logic [oaie_pkg::POS_W-1:0] pos);
        outcome_t        res;
        oaie_pkg::word_t key;
        int              kept;
        res  = '0;
        key  = oaie_pkg::widen_value(val);
        kept = 0;
        case (op)
            oaie_pkg::OP_APPEND:
            begin
                if (list_len >= oaie_pkg::CAPACITY)
                    res.status = oaie_pkg::STATUS_FULL;
                else
                begin
                    list_words[list_len] = key;
                    list_len++;
                end
            end
            oaie_pkg::OP_INSERT:
            begin
                if (list_len >= oaie_pkg::CAPACITY)
                    res.status = oaie_pkg::STATUS_FULL;
                else if (int'(pos) > list_len)
                    res.status = oaie_pkg::STATUS_RANGE;
                else
                begin
                    for (int i = list_len; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = key;
                    list_len++;
                end
            end
            oaie_pkg::OP_ERASE:
            begin
                for (int i = 0; i < list_len; i++)
                begin
                    if (list_words[i] != key)
                    begin
                        list_words[kept] = list_words[i];
                        kept++;
                    end
                end
                if (kept == list_len)
                    res.status = oaie_pkg::STATUS_MISSING;
                list_len = kept;
            end
            oaie_pkg::OP_FIND:
            begin
                res.status = oaie_pkg::STATUS_MISSING;
                for (int i = list_len - 1; i >= 0; i--)
                begin
                    if (list_words[i] == key)
                    begin
                        res.status = oaie_pkg::STATUS_OK;
                        res.fpos   = oaie_pkg::FPOS_W'(i);
                    end
                end
            end
            oaie_pkg::OP_READ:
            begin
                if (int'(pos) >= list_len)
                    res.status = oaie_pkg::STATUS_RANGE;
                else
                    res.rword = oaie_pkg::to_read_word(list_words[pos]);
            end
            default:
            begin
            end
        endcase
        res.count = oaie_pkg::ENTRY_CT_W'(list_len);
        return res;
    endfunction

    function automatic logic signed [oaie_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 3) != 0)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic signed [oaie_pkg::VALUE_W-1:0] pick_key();
        if (list_len > 0 && $urandom_range(0, 99) < 65)
            return list_words[$urandom_range(0, list_len - 1)];
        return pick_value();
    endfunction

    // called at a falling edge; may drop valid for a gap between bursts
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_request(input logic [oaie_pkg::OP_W-1:0] op,
                                input logic signed [oaie_pkg::VALUE_W-1:0] val,
                                input logic [oaie_pkg::POS_W-1:0] pos,
                                input bit has_want,
                                input outcome_t want);
        outcome_t model_out;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= val;
        req_ch.position  <= pos;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        model_out = apply_request(op, val, pos);
        if (has_want)
            model_out = want;
        outcome_q = {outcome_q, model_out};
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // result side stalls
    initial
    begin
        int mode;
        int span;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            for (int tick = 0; tick < span; tick++)
            begin
                @(negedge clk);
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 2) != 0);
                    2:       rsp_ch.ready <= (tick % 4 != 3);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result with no request pending");
                mismatches++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.found_position !== want.fpos)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.fpos, rsp_ch.found_position);
                    mismatches++;
                end
                if (rsp_ch.read_word !== want.rword)
                begin
                    $error("read_word: expected %h, got %h", want.rword, rsp_ch.read_word);
                    mismatches++;
                end
                if (rsp_ch.entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.count, rsp_ch.entry_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [oaie_pkg::OP_W-1:0]           op;
        logic signed [oaie_pkg::VALUE_W-1:0] val;
        logic [oaie_pkg::POS_W-1:0]          pos;
        int                                  sent;
        int                                  r;
        bit                                  few;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = '0;
        req_ch.value     = '0;
        req_ch.position  = '0;
        list_len         = 0;
        burst_left       = 0;
        mismatches       = 0;
        sent             = 0;
        foreach (list_words[i])
            list_words[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int row = 0; row < N_DIRECTED; row++)
        begin
            repeat (directed_rows[row].reps)
            begin
                pace_sender();
                send_request(directed_rows[row].op, directed_rows[row].value,
                             directed_rows[row].pos, directed_rows[row].has_want,
                             directed_rows[row].want);
            end
        end

        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 200 == 0)
            begin
                foreach (value_pool[i])
                begin
                    case ($urandom_range(0, 9))
                        0:       value_pool[i] = 32'sh7FFF_FFFF;
                        1:       value_pool[i] = 32'sh8000_0000;
                        2:       value_pool[i] = 32'sd0;
                        3:       value_pool[i] = -32'sd1;
                        4:       value_pool[i] = $urandom_range(0, 3);
                        default: value_pool[i] = $urandom;
                    endcase
                end
            end

            r   = $urandom_range(0, 99);
            few = (list_len < 4);
            if (list_len == oaie_pkg::CAPACITY && $urandom_range(0, 2) == 0)
                op = oaie_pkg::OP_ERASE;
            else if (r < (few ? 35 : 20))
                op = oaie_pkg::OP_APPEND;
            else if (r < (few ? 65 : 40))
                op = oaie_pkg::OP_INSERT;
            else if (r < (few ? 72 : 54))
                op = oaie_pkg::OP_ERASE;
            else if (r < (few ? 82 : 72))
                op = oaie_pkg::OP_FIND;
            else if (r < 97)
                op = oaie_pkg::OP_READ;
            else
                op = oaie_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

            if (op == oaie_pkg::OP_ERASE || op == oaie_pkg::OP_FIND)
                val = pick_key();
            else
                val = pick_value();

            if (op == oaie_pkg::OP_INSERT && $urandom_range(0, 4) != 0)
                pos = oaie_pkg::POS_W'($urandom_range(0, list_len));
            else if (op == oaie_pkg::OP_READ && list_len > 0 && $urandom_range(0, 4) != 0)
                pos = oaie_pkg::POS_W'($urandom_range(0, list_len - 1));
            else
                pos = oaie_pkg::POS_W'($urandom_range(0, 31));

            pace_sender();
            send_request(op, val, pos, 1'b0, '0);
            sent++;
        end

        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
